### rtl/pddl_token_lexer_macros.svh
// ----------------------------------------------------------------------------
// PDDL token lexer assertion macros
// Shared concurrent assertion forms for the lexer checker.
// ----------------------------------------------------------------------------
`ifndef PDDL_TOKEN_LEXER_MACROS_SVH
`define PDDL_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PDL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PDL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pddl_lex_pkg.sv
// ----------------------------------------------------------------------------
// PDDL lexer package
// Types, constants, keyword tables and character class functions.
// ----------------------------------------------------------------------------
package pddl_lex_pkg;

    localparam int MAX_MATCH_LEN_DEF = 13;
    localparam int POS_WIDTH_DEF     = 24;
    localparam int KW_CHARS          = 13;
    localparam int OUT_POS_W         = 24;
    localparam int LEN_W             = 16;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        LEX_IDLE = 2'd0,
        LEX_WORD = 2'd1,
        LEX_HALT = 2'd2
    } t_lex_mode;

    typedef enum logic [1:0] {
        CLS_ID  = 2'd0,
        CLS_VAR = 2'd1,
        CLS_DEF = 2'd2
    } t_word_class;

    typedef enum logic [1:0] {
        ST_TOKEN    = 2'd0,
        ST_END      = 2'd1,
        ST_BAD_CHAR = 2'd2,
        ST_BAD_DEF  = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        K_DEF_DEFINE       = 5'd0,
        K_DEF_NAME         = 5'd1,
        K_DEF_REQUIREMENTS = 5'd2,
        K_DEF_PREDICATES   = 5'd3,
        K_DEF_ACTION       = 5'd4,
        K_DEF_PARAMETERS   = 5'd5,
        K_DEF_PRECONDITION = 5'd6,
        K_DEF_EFFECT       = 5'd7,
        K_DEF_DOMAIN       = 5'd8,
        K_DEF_OBJECTS      = 5'd9,
        K_DEF_INIT         = 5'd10,
        K_DEF_GOAL         = 5'd11,
        K_REQ_STRIPS       = 5'd12,
        K_EXP_AND          = 5'd13,
        K_EXP_NOT          = 5'd14,
        K_EXP_OR           = 5'd15,
        K_LPAREN           = 5'd16,
        K_RPAREN           = 5'd17,
        K_VARIABLE         = 5'd18,
        K_ID               = 5'd19
    } t_token_kind;

    typedef struct packed {
        t_status               status;
        t_token_kind           kind;
        logic [OUT_POS_W-1:0]  pos;
        logic [LEN_W-1:0]      len;
        logic                  last;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    typedef logic [KW_CHARS-1:0][7:0] t_win;

    typedef struct packed {
        logic [8*KW_CHARS-1:0] text;
        logic [3:0]            len;
        t_token_kind           kind;
    } t_word_ent;

    typedef struct packed {
        logic        hit;
        t_token_kind kind;
    } t_lookup;

    localparam int DEF_COUNT = 11;
    localparam int KWD_COUNT = 6;

    localparam t_word_ent DEF_TABLE [DEF_COUNT] = '{
        '{text: ":requirements", len: 4'd13, kind: K_DEF_REQUIREMENTS},
        '{text: ":predicates",   len: 4'd11, kind: K_DEF_PREDICATES},
        '{text: ":action",       len: 4'd7,  kind: K_DEF_ACTION},
        '{text: ":parameters",   len: 4'd11, kind: K_DEF_PARAMETERS},
        '{text: ":precondition", len: 4'd13, kind: K_DEF_PRECONDITION},
        '{text: ":effect",       len: 4'd7,  kind: K_DEF_EFFECT},
        '{text: ":domain",       len: 4'd7,  kind: K_DEF_DOMAIN},
        '{text: ":objects",      len: 4'd8,  kind: K_DEF_OBJECTS},
        '{text: ":init",         len: 4'd5,  kind: K_DEF_INIT},
        '{text: ":goal",         len: 4'd5,  kind: K_DEF_GOAL},
        '{text: ":strips",       len: 4'd7,  kind: K_REQ_STRIPS}
    };

    localparam t_word_ent KWD_TABLE [KWD_COUNT] = '{
        '{text: "define",  len: 4'd6, kind: K_DEF_DEFINE},
        '{text: "domain",  len: 4'd6, kind: K_DEF_NAME},
        '{text: "problem", len: 4'd7, kind: K_DEF_NAME},
        '{text: "and",     len: 4'd3, kind: K_EXP_AND},
        '{text: "not",     len: 4'd3, kind: K_EXP_NOT},
        '{text: "or",      len: 4'd2, kind: K_EXP_OR}
    };

    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_NUL    = 8'h00;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_word_byte(input logic [7:0] c);
        return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_DASH || c == CH_UNDER;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    // The text field holds the first character in its highest used byte.
    function automatic logic word_hit(input t_word_ent ent, input t_win win,
                                      input logic [LEN_W-1:0] len);
        logic hit;
        int   idx;
        hit = (len == LEN_W'(ent.len));
        for (int j = 0; j < KW_CHARS; j++) begin
            idx = int'(ent.len) - 1 - j;
            if (idx >= 0) begin
                if (win[j] != ent.text[8*idx +: 8]) begin
                    hit = 1'b0;
                end
            end
        end
        return hit;
    endfunction

    function automatic t_lookup lookup_def(input t_win win, input logic [LEN_W-1:0] len);
        t_lookup res;
        res = '{hit: 1'b0, kind: K_DEF_DEFINE};
        for (int i = 0; i < DEF_COUNT; i++) begin
            if (!res.hit && word_hit(DEF_TABLE[i], win, len)) begin
                res = '{hit: 1'b1, kind: DEF_TABLE[i].kind};
            end
        end
        return res;
    endfunction

    function automatic t_lookup lookup_kwd(input t_win win, input logic [LEN_W-1:0] len);
        t_lookup res;
        res = '{hit: 1'b0, kind: K_DEF_DEFINE};
        for (int i = 0; i < KWD_COUNT; i++) begin
            if (!res.hit && word_hit(KWD_TABLE[i], win, len)) begin
                res = '{hit: 1'b1, kind: KWD_TABLE[i].kind};
            end
        end
        return res;
    endfunction

endpackage

### rtl/pddl_lex_if.sv
// ----------------------------------------------------------------------------
// PDDL lexer channel interfaces
// Valid/ready channels for input bytes and for result words.
// ----------------------------------------------------------------------------
interface pddl_lex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface pddl_lex_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  token_kind;
    logic [23:0] token_pos;
    logic [15:0] token_len;
    logic        last;

    modport source (output valid, output status, output token_kind, output token_pos,
                    output token_len, output last, input ready);
    modport sink   (input valid, input status, input token_kind, input token_pos,
                    input token_len, input last, output ready);
endinterface

### rtl/pddl_token_lexer.sv
// ----------------------------------------------------------------------------
// PDDL token lexer
// Lexes a planning-language text byte by byte into token results.
//
// Channel   Dir  Payload
// i_in      in   char_in
// o_out     out  status, token_kind, token_pos, token_len, last
//
// One byte is taken per cycle while the queue has room. Results are written
// to a four-entry queue at the edge that takes the byte and leave on o_out
// one per cycle while o_out is ready. The front end stalls i_in only while
// fewer than two queue entries are free. Reset is synchronous and clears the
// lexer state and the queue; the word character store needs no clearing.
// ----------------------------------------------------------------------------
module pddl_token_lexer import pddl_lex_pkg::*; #(
    parameter int MAX_MATCH_LEN = MAX_MATCH_LEN_DEF,
    parameter int POS_WIDTH     = POS_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pddl_lex_in_if.sink           i_in,
    pddl_lex_out_if.source        o_out
);

    t_push   push;
    logic    room;
    logic    q_valid;
    t_result q_data;

    pddl_lex_front #(
        .MAX_MATCH_LEN (MAX_MATCH_LEN),
        .POS_WIDTH     (POS_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_char  (i_in.char_in),
        .o_ready (i_in.ready),
        .i_room  (room),
        .o_push  (push)
    );

    pddl_lex_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (q_valid),
        .i_ready (o_out.ready),
        .o_data  (q_data)
    );

    assign o_out.valid      = q_valid;
    assign o_out.status     = q_data.status;
    assign o_out.token_kind = q_data.kind;
    assign o_out.token_pos  = q_data.pos;
    assign o_out.token_len  = q_data.len;
    assign o_out.last       = q_data.last;

endmodule

### rtl/pddl_lex_front.sv
// ----------------------------------------------------------------------------
// PDDL lexer front end
// Classifies each byte, tracks the current word and builds up to two results.
// ----------------------------------------------------------------------------
module pddl_lex_front import pddl_lex_pkg::*; #(
    parameter int MAX_MATCH_LEN = MAX_MATCH_LEN_DEF,
    parameter int POS_WIDTH     = POS_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    output logic       o_ready,
    input  logic       i_room,
    output t_push      o_push
);

    localparam int IDX_W = $clog2(MAX_MATCH_LEN);
    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
    localparam logic [LEN_W-1:0]     LEN_MAX = {LEN_W{1'b1}};

    t_lex_mode            r_mode, n_mode;
    t_word_class          r_cls, n_cls;
    logic [POS_WIDTH-1:0] r_pos, n_pos;
    logic [POS_WIDTH-1:0] r_start, n_start;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [7:0]           r_chars [MAX_MATCH_LEN];

    logic             fire;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       wr_data;
    logic             lex_char;
    logic             word_vld;
    logic             char_vld;
    t_result          word_res;
    t_result          char_res;
    t_win             win;
    t_lookup          def_lu;
    t_lookup          kwd_lu;

    assign o_ready = i_room;
    assign fire    = i_valid && i_room;

    always_comb begin
        for (int j = 0; j < KW_CHARS; j++) begin
            win[j] = r_chars[j];
        end
    end

    assign def_lu = lookup_def(win, r_len);
    assign kwd_lu = lookup_kwd(win, r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= LEX_IDLE;
        end else begin
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls   <= CLS_ID;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
        end else begin
            r_cls   <= n_cls;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_chars[wr_idx] <= wr_data;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_cls    = r_cls;
        n_pos    = r_pos;
        n_start  = r_start;
        n_len    = r_len;
        wr_en    = 1'b0;
        wr_idx   = '0;
        wr_data  = '0;
        lex_char = 1'b0;
        word_vld = 1'b0;
        char_vld = 1'b0;
        word_res = '{status: ST_TOKEN, kind: K_DEF_DEFINE, pos: '0, len: '0, last: 1'b0};
        char_res = '{status: ST_TOKEN, kind: K_DEF_DEFINE, pos: OUT_POS_W'(r_pos),
                     len: LEN_W'(1), last: 1'b1};
        o_push   = '0;

        if (fire && r_mode != LEX_HALT) begin
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
            lex_char = 1'b1;

            if (r_mode == LEX_WORD) begin
                if (is_word_byte(i_char)) begin
                    lex_char = 1'b0;
                    if (r_len < LEN_W'(MAX_MATCH_LEN)) begin
                        wr_en   = 1'b1;
                        wr_idx  = r_len[IDX_W-1:0];
                        wr_data = to_lower(i_char);
                    end
                    if (r_len != LEN_MAX) begin
                        n_len = r_len + 1'b1;
                    end
                end else begin
                    n_mode       = LEX_IDLE;
                    word_vld     = 1'b1;
                    word_res.pos = OUT_POS_W'(r_start);
                    word_res.len = r_len;
                    unique case (r_cls)
                        CLS_DEF: begin
                            if (def_lu.hit) begin
                                word_res.kind = def_lu.kind;
                            end else begin
                                word_res.status = ST_BAD_DEF;
                                n_mode          = LEX_HALT;
                                lex_char        = 1'b0;
                            end
                        end
                        CLS_VAR: begin
                            word_res.kind = K_VARIABLE;
                        end
                        CLS_ID: begin
                            word_res.kind = kwd_lu.hit ? kwd_lu.kind : K_ID;
                        end
                        default: begin
                            word_res.kind = K_ID;
                        end
                    endcase
                end
            end

            if (lex_char) begin
                if (is_space(i_char)) begin
                    char_vld = 1'b0;
                end else if (i_char == CH_NUL) begin
                    char_vld        = 1'b1;
                    char_res.status = ST_END;
                    char_res.len    = '0;
                end else if (i_char == CH_LPAREN) begin
                    char_vld      = 1'b1;
                    char_res.kind = K_LPAREN;
                end else if (i_char == CH_RPAREN) begin
                    char_vld      = 1'b1;
                    char_res.kind = K_RPAREN;
                end else if (i_char == CH_COLON || i_char == CH_QUEST || is_alpha(i_char)) begin
                    n_mode  = LEX_WORD;
                    n_cls   = (i_char == CH_COLON) ? CLS_DEF :
                              (i_char == CH_QUEST) ? CLS_VAR : CLS_ID;
                    n_start = r_pos;
                    n_len   = LEN_W'(1);
                    wr_en   = 1'b1;
                    wr_idx  = '0;
                    wr_data = to_lower(i_char);
                end else begin
                    char_vld        = 1'b1;
                    char_res.status = ST_BAD_CHAR;
                    n_mode          = LEX_HALT;
                end
            end

            if (word_vld && char_vld) begin
                o_push.cnt = 2'd2;
                o_push.r0  = word_res;
                o_push.r1  = char_res;
            end else if (word_vld) begin
                o_push.cnt     = 2'd1;
                o_push.r0      = word_res;
                o_push.r0.last = 1'b1;
            end else if (char_vld) begin
                o_push.cnt = 2'd1;
                o_push.r0  = char_res;
            end
        end
    end

endmodule

### rtl/pddl_lex_queue.sv
// ----------------------------------------------------------------------------
// PDDL lexer result queue
// Takes up to two result words a cycle and hands out one a cycle while the sink is ready.
// ----------------------------------------------------------------------------
module pddl_lex_queue import pddl_lex_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_room  = (r_cnt <= QCNT_W'(QUEUE_DEPTH - 2));
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr  = r_wr + QPTR_W'(i_push.cnt);
        n_rd  = r_rd + QPTR_W'(pop);
        n_cnt = r_cnt + QCNT_W'(i_push.cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[QPTR_W'(r_wr + 1'b1)] <= i_push.r1;
        end
    end

endmodule

### rtl/pddl_lex_checker.sv
// ----------------------------------------------------------------------------
// PDDL lexer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "pddl_token_lexer_macros.svh"

module pddl_lex_checker import pddl_lex_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [4:0]  i_kind,
    input logic [15:0] i_len,
    input logic        i_last
);

    `PDL_ASSERT_NXT(a_valid_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result word dropped while stalled")
    `PDL_ASSERT_NXT(a_data_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_status) && $stable(i_len), "result word changed while stalled")
    `PDL_ASSERT_IMP(a_kind_zero, i_clk, i_rst_n, i_out_valid && i_status != ST_TOKEN, i_kind == '0, "token kind set on a status word")
    `PDL_ASSERT_IMP(a_err_last, i_clk, i_rst_n, i_out_valid && (i_status == ST_BAD_CHAR || i_status == ST_BAD_DEF), i_last, "error word not marked last")
    `PDL_ASSERT_IMP(a_end_len, i_clk, i_rst_n, i_out_valid && i_status == ST_END, i_len == '0 && i_last, "end word with length or not last")

endmodule

bind pddl_token_lexer pddl_lex_checker u_lex_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_kind      (o_out.token_kind),
    .i_len       (o_out.token_len),
    .i_last      (o_out.last)
);
